/* hdl/wlca_pkg.sv */
package wlca_pkg;

  // Lane count and field widths.
  localparam int LANES   = 4;
  localparam int LANE_W  = 2;
  localparam int WEIGHT_W = 16;
  localparam int CREDIT_W = 64;
  localparam int ACTIVE_W = 18;
  localparam int CFG_IDX_W = 3;

  // Request operation codes.
  localparam logic OP_SELECT  = 1'b0;
  localparam logic OP_ACCOUNT = 1'b1;

  // Weight register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_LANE0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_LANE1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_LANE2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_LANE3 = 3'd3;

  localparam logic signed [CREDIT_W-1:0] CREDIT_MAX = {1'b0, {(CREDIT_W-1){1'b1}}};
  localparam logic signed [CREDIT_W-1:0] CREDIT_MIN = {1'b1, {(CREDIT_W-1){1'b0}}};

  typedef logic [WEIGHT_W-1:0] weight_t;
  typedef logic signed [CREDIT_W-1:0] credit_t;

  // Candidate in the grant comparison tree.
  typedef struct packed {
    logic              present;
    credit_t           credit;
    weight_t           weight;
    logic [LANE_W-1:0] lane;
  } cand_t;

  // Larger of two candidates; b carries the higher lane index, so it wins full ties.
  function automatic cand_t pick(input cand_t a, input cand_t b);
    cand_t res;
    res = a;
    if (b.present) begin
      if (!a.present || (b.credit > a.credit) ||
          ((b.credit == a.credit) && (b.weight >= a.weight))) begin
        res = b;
      end
    end
    return res;
  endfunction

  // Credit plus weight, clamped at the positive limit.
  function automatic credit_t credit_add(input credit_t c, input weight_t w);
    logic signed [CREDIT_W:0] s;
    credit_t res;
    s = {c[CREDIT_W-1], c} + $signed({{(CREDIT_W-WEIGHT_W+1){1'b0}}, w});
    if (s[CREDIT_W:CREDIT_W-1] == 2'b01) begin
      res = CREDIT_MAX;
    end else begin
      res = s[CREDIT_W-1:0];
    end
    return res;
  endfunction

  // Credit minus active weight sum, clamped at the negative limit.
  function automatic credit_t credit_sub(input credit_t c, input logic [ACTIVE_W-1:0] a);
    logic signed [CREDIT_W:0] d;
    credit_t res;
    d = {c[CREDIT_W-1], c} - $signed({{(CREDIT_W-ACTIVE_W+1){1'b0}}, a});
    if (d[CREDIT_W:CREDIT_W-1] == 2'b10) begin
      res = CREDIT_MIN;
    end else begin
      res = d[CREDIT_W-1:0];
    end
    return res;
  endfunction

endpackage

/* hdl/weighted_lane_credit_arbiter.sv */
// Smooth weighted round-robin arbiter over four lanes.
// Input channel (in_valid / in_stall): a select request (in_op = 0) names the
// lanes with waiting work in in_lane_mask; an account request (in_op = 1)
// names the active lanes and the lane that was served in in_served_lane.
// Result channel (out_valid / out_stall): one result per request. A select
// returns the present lane with the highest credit (ties to the larger
// weight, then the higher lane) or out_granted = 0 on an empty mask. An
// account returns out_granted = 0 and updates the signed 64-bit credits.
// The user must write weights through cfg_wr_en / cfg_index / cfg_wdata
// only while idle; the block does not enforce it. A request passes the input
// register and then the result register; out_valid rises once the grant and
// credit logic behind the input register have fed the result register. One
// request is accepted every cycle while the receiver does not stall; the
// credit update and the grant both run in the cycle a request leaves the
// input register, so a request sees the credits left by the one before it.
// When the receiver stalls, the result register holds and the input register
// fills; in_stall rises once both are occupied.
// Reset clears all credits to zero, sets all weights to one and empties both
// registers.
module weighted_lane_credit_arbiter
  import wlca_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WEIGHT_W-1:0]  cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_op,
  input  logic [LANES-1:0]     in_lane_mask,
  input  logic [LANE_W-1:0]    in_served_lane,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_granted,
  output logic [LANE_W-1:0]    out_grant_lane
);

  weight_t           weight_r [LANES];
  credit_t           credit_r [LANES];
  credit_t           credit_nxt [LANES];

  logic              req_valid_r;
  logic              req_op_r;
  logic [LANES-1:0]  req_mask_r;
  logic [LANE_W-1:0] req_served_r;

  logic              out_valid_r;
  logic              out_granted_r;
  logic [LANE_W-1:0] out_lane_r;

  logic              advance;
  logic              in_take;
  cand_t             cand [LANES];
  cand_t             win_lo;
  cand_t             win_hi;
  cand_t             win;
  logic [ACTIVE_W-1:0] active_sum;
  logic              granted_nxt;

  // Handshake: the input register moves on when the result register is free or its result is being taken.
  assign advance  = req_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = req_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  // Weight registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LANES; i++) begin
        weight_r[i] <= weight_t'(1);
      end
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_WEIGHT_LANE0: weight_r[0] <= cfg_wdata;
        REG_WEIGHT_LANE1: weight_r[1] <= cfg_wdata;
        REG_WEIGHT_LANE2: weight_r[2] <= cfg_wdata;
        REG_WEIGHT_LANE3: weight_r[3] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
    end else if (in_take) begin
      req_valid_r <= 1'b1;
    end else if (advance) begin
      req_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      req_op_r     <= in_op;
      req_mask_r   <= in_lane_mask;
      req_served_r <= in_served_lane;
    end
  end

  // Grant selection: a two-level comparison tree over the present lanes.
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      cand[i].present = req_mask_r[i];
      cand[i].credit  = credit_r[i];
      cand[i].weight  = weight_r[i];
      cand[i].lane    = LANE_W'(i);
    end
    win_lo = pick(cand[0], cand[1]);
    win_hi = pick(cand[2], cand[3]);
    win    = pick(win_lo, win_hi);
    granted_nxt = (req_op_r == OP_SELECT) && win.present;
  end

  // Credit accounting: active lanes gain their weight, the served lane pays the sum.
  always_comb begin
    active_sum = '0;
    for (int i = 0; i < LANES; i++) begin
      if (req_mask_r[i]) begin
        active_sum = active_sum + ACTIVE_W'(weight_r[i]);
      end
    end
    for (int i = 0; i < LANES; i++) begin
      credit_nxt[i] = req_mask_r[i] ? credit_add(credit_r[i], weight_r[i]) : credit_r[i];
      if (req_served_r == LANE_W'(i)) begin
        credit_nxt[i] = credit_sub(credit_nxt[i], active_sum);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LANES; i++) begin
        credit_r[i] <= '0;
      end
    end else if (advance && (req_op_r == OP_ACCOUNT)) begin
      for (int i = 0; i < LANES; i++) begin
        credit_r[i] <= credit_nxt[i];
      end
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_granted_r <= granted_nxt;
      out_lane_r    <= granted_nxt ? win.lane : '0;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_granted    = out_granted_r;
  assign out_grant_lane = out_lane_r;

  // A result without a grant always reports lane zero.
  a_lane_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_granted_r) |-> (out_lane_r == '0))
    else $error("grant lane nonzero without a grant");

  // A granted lane was present in the select mask.
  a_grant_present: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && granted_nxt) |-> req_mask_r[win.lane])
    else $error("granted lane not in the mask");

  // Select requests never change the credits.
  a_select_no_update: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && (req_op_r == OP_SELECT)) |=>
      ($stable(credit_r[0]) && $stable(credit_r[1]) &&
       $stable(credit_r[2]) && $stable(credit_r[3])))
    else $error("credits changed on a select request");

  // An account request never yields a grant.
  a_account_no_grant: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && (req_op_r == OP_ACCOUNT)) |=> !out_granted_r)
    else $error("grant reported for an account request");

endmodule
